// ===== rtl/pal_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the array list.
`default_nettype none
package pal_pkg;

  // Capacity and element size
  localparam int MAX_ENTRIES = 256;
  localparam int ELEM_W      = 32;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Port field widths
  localparam int CMD_W  = 2;
  localparam int POS_W  = 9;
  localparam int VAL_W  = 32;
  localparam int STS_W  = 2;
  localparam int ITEM_W = 32;

  // Width for position/count compares
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LOCATE = 2'd3;

  // Result status codes
  localparam logic [STS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STS_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STS_W-1:0] ST_EMPTY  = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load_req;    // capture an accepted request
    logic start_walk;  // load walk start and end addresses
    logic step;        // read entry at walk index, advance index
    logic put;         // write the request value at its position
    logic finish;      // load result beat, commit entry count
  } pal_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ok;          // request passes its checks
    logic skip;        // nothing to walk
    logic last;        // walk index is at its end address
    logic ins;         // request is an insert
    logic out_free;    // result register can take a beat
  } pal_sts_t;

endpackage
`default_nettype wire

// ===== rtl/pal_ctrl.sv =====
// Sequencer for the array list: check, memory walk, drain, put and result handoff.
`default_nettype none
module pal_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pal_pkg::pal_sts_t sts,
  output pal_pkg::pal_cmd_t      cmd
);
  import pal_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_r, state_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.ok) begin
          state_nxt = S_FIN;
        end else if (sts.skip) begin
          state_nxt = sts.ins ? S_PUT : S_FIN;
        end else begin
          cmd.start_walk = 1'b1;
          state_nxt      = S_WALK;
        end
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (sts.last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = sts.ins ? S_PUT : S_FIN;
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/pal_dp.sv =====
// Datapath: entry memory, count, request registers, walk index and result register.
`default_nettype none
module pal_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pal_pkg::pal_cmd_t             cmd,
  output pal_pkg::pal_sts_t                  sts,
  input  wire logic [pal_pkg::CMD_W-1:0]     in_command,
  input  wire logic [pal_pkg::POS_W-1:0]     in_position,
  input  wire logic [pal_pkg::VAL_W-1:0]     in_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [pal_pkg::STS_W-1:0]          out_status,
  output logic [pal_pkg::ITEM_W-1:0]         out_item,
  output logic [pal_pkg::POS_W-1:0]          out_found_at,
  output logic [pal_pkg::POS_W-1:0]          out_count
);
  import pal_pkg::*;

  logic [ELEM_W-1:0] mem_r [MAX_ENTRIES];

  logic [CMD_W-1:0]  op_r;
  logic [POS_W-1:0]  pos_r;
  logic [ELEM_W-1:0] val_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [ADDR_W-1:0] idx_r, end_r, ra_r;
  logic              rv_r;
  logic [ELEM_W-1:0] rd_data_r;
  logic [ELEM_W-1:0] item_r;
  logic [CNT_W-1:0]  found_r;

  logic              out_valid_r;
  logic [STS_W-1:0]  out_status_r;
  logic [ITEM_W-1:0] out_item_r;
  logic [POS_W-1:0]  out_found_r, out_count_r;

  logic [CMP_W-1:0]  pos_x, cnt_x;
  logic [STS_W-1:0]  status;
  logic [ADDR_W-1:0] pos_addr, cnt_last, start_addr, end_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ELEM_W-1:0] wr_data;
  logic [CNT_W-1:0]  cnt_nxt;

  assign pos_x    = CMP_W'(pos_r);
  assign cnt_x    = CMP_W'(cnt_r);
  assign pos_addr = ADDR_W'(pos_r - POS_W'(1));
  assign cnt_last = ADDR_W'(cnt_r - CNT_W'(1));

  // Request checks
  always_comb begin
    status = ST_OK;
    unique case (op_r)
      CMD_INSERT: begin
        if (cnt_r == CNT_W'(MAX_ENTRIES))                  status = ST_FULL;
        else if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) status = ST_BADPOS;
      end
      CMD_DELETE: begin
        if (cnt_r == '0)                        status = ST_EMPTY;
        else if (pos_x == '0 || pos_x > cnt_x) status = ST_BADPOS;
      end
      CMD_GET: begin
        if (pos_x == '0 || pos_x > cnt_x) status = ST_BADPOS;
      end
      default: status = ST_OK;
    endcase
  end

  // Walk range: insert shifts down from the top, the rest walk upward
  always_comb begin
    start_addr = pos_addr;
    end_addr   = pos_addr;
    unique case (op_r)
      CMD_INSERT: begin
        start_addr = cnt_last;
        end_addr   = pos_addr;
      end
      CMD_DELETE: begin
        start_addr = pos_addr;
        end_addr   = cnt_last;
      end
      CMD_GET: begin
        start_addr = pos_addr;
        end_addr   = pos_addr;
      end
      default: begin
        start_addr = '0;
        end_addr   = cnt_last;
      end
    endcase
  end

  assign sts.ok       = (status == ST_OK);
  assign sts.skip     = ((op_r == CMD_INSERT) && (pos_x == cnt_x + CMP_W'(1))) ||
                        ((op_r == CMD_LOCATE) && (cnt_r == '0));
  assign sts.last     = (idx_r == end_r);
  assign sts.ins      = (op_r == CMD_INSERT);
  assign sts.out_free = !out_valid_r || out_ready;

  // Memory write port: put, shift-up writeback or shift-down writeback
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ra_r;
    wr_data = rd_data_r;
    if (cmd.put) begin
      wr_en   = 1'b1;
      wr_addr = pos_addr;
      wr_data = val_r;
    end else if (rv_r && op_r == CMD_INSERT) begin
      wr_en   = 1'b1;
      wr_addr = ra_r + ADDR_W'(1);
    end else if (rv_r && op_r == CMD_DELETE && ra_r != pos_addr) begin
      wr_en   = 1'b1;
      wr_addr = ra_r - ADDR_W'(1);
    end
  end

  // Entry memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en)    mem_r[wr_addr] <= wr_data;
    if (cmd.step) rd_data_r      <= mem_r[idx_r];
  end

  // Request capture and walk index
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r  <= in_command;
      pos_r <= in_position;
      val_r <= ELEM_W'(in_value);
    end
    if (cmd.start_walk) begin
      idx_r <= start_addr;
      end_r <= end_addr;
    end else if (cmd.step) begin
      idx_r <= (op_r == CMD_INSERT) ? idx_r - ADDR_W'(1) : idx_r + ADDR_W'(1);
    end
    if (cmd.step) ra_r <= idx_r;
  end

  // Read-data consumers: removed/fetched item and first match
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      item_r  <= '0;
      found_r <= '0;
    end else if (rv_r) begin
      if ((op_r == CMD_DELETE && ra_r == pos_addr) || op_r == CMD_GET)
        item_r <= rd_data_r;
      if (op_r == CMD_LOCATE && found_r == '0 && rd_data_r == val_r)
        found_r <= CNT_W'(ra_r) + CNT_W'(1);
    end
  end

  // Count after a successful insert or delete
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.finish && status == ST_OK) begin
      if (op_r == CMD_INSERT)      cnt_nxt = cnt_r + CNT_W'(1);
      else if (op_r == CMD_DELETE) cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rv_r  <= cmd.step;
      if (cmd.finish)     out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Result beat payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= status;
      out_item_r   <= ITEM_W'(item_r);
      out_found_r  <= POS_W'(found_r);
      out_count_r  <= POS_W'(cnt_nxt);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_item     = out_item_r;
  assign out_found_at = out_found_r;
  assign out_count    = out_count_r;

endmodule
`default_nettype wire

// ===== rtl/positional_array_list_unit.sv =====
// Top level of the array list: sequencer plus datapath with the entry memory.
// Insert, delete, get and locate walk the entry memory, n being
//   the entries walked: insert n = used - position + 1, delete n = used - position + 1,
//   get n = 1, locate n = used; failed requests, insert at the end and locate on an empty list skip the walk.
// One request is in flight at a time; the walk reads one entry per cycle through
// the memory's single read port.
// Synchronous active-low reset empties the list; entry contents stay undefined.
`default_nettype none
module positional_array_list_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [pal_pkg::CMD_W-1:0] in_command,
  input  wire logic [pal_pkg::POS_W-1:0] in_position,
  input  wire logic [pal_pkg::VAL_W-1:0] in_value,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [pal_pkg::STS_W-1:0]      out_status,
  output logic [pal_pkg::ITEM_W-1:0]     out_item,
  output logic [pal_pkg::POS_W-1:0]      out_found_at,
  output logic [pal_pkg::POS_W-1:0]      out_count
);
  import pal_pkg::*;

  pal_cmd_t cmd;
  pal_sts_t sts;

  // Sequencer
  pal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  pal_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_command   (in_command),
    .in_position  (in_position),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_item     (out_item),
    .out_found_at (out_found_at),
    .out_count    (out_count)
  );

endmodule
`default_nettype wire

// ===== rtl/pal_checker.sv =====
// Port-level checker for the array list and its bind to the top level.
`default_nettype none
module pal_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [pal_pkg::STS_W-1:0] out_status,
  input wire logic [pal_pkg::ITEM_W-1:0] out_item,
  input wire logic [pal_pkg::POS_W-1:0] out_found_at,
  input wire logic [pal_pkg::POS_W-1:0] out_count
);
  import pal_pkg::*;

  // A stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // Full status only with a full list
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_count == POS_W'(MAX_ENTRIES))
    else $error("full status with list not full");

  // Empty status only with an empty list
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_count == '0)
    else $error("empty status with entries present");

  // Failed requests return no item and no position
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_item == '0 && out_found_at == '0)
    else $error("failed request returned data");

  // A found position lies inside the list
  a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found_at != '0 |-> out_found_at <= out_count)
    else $error("found position beyond list end");

endmodule

bind positional_array_list_unit pal_checker u_pal_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_status   (out_status),
  .out_item     (out_item),
  .out_found_at (out_found_at),
  .out_count    (out_count)
);
`default_nettype wire
